### rtl/rfef_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rfef_pkg;

  localparam int COORD_BITS     = 10;
  localparam int CURVE_ENTRIES  = 256;   // power of two
  localparam int IDX_BITS       = $clog2(CURVE_ENTRIES);
  localparam int HEIGHT_BITS    = 8;
  localparam int RAD_BITS       = 8;
  localparam int CFG_DATA_BITS  = (COORD_BITS > RAD_BITS) ? COORD_BITS : RAD_BITS;
  localparam int CFG_INDEX_BITS = 3;

  localparam int DIST_FRAC   = 8;
  localparam int W_FRAC      = 12;
  localparam int W_BITS      = W_FRAC + 1;
  localparam int SQ_BITS     = 2 * COORD_BITS;
  localparam int RSQ_BITS    = 2 * RAD_BITS;
  localparam int OUTER_BITS  = RAD_BITS + 1;
  localparam int OSQ_BITS    = 2 * OUTER_BITS;
  localparam int D2_BITS     = (SQ_BITS + 1 > OSQ_BITS) ? SQ_BITS + 1 : OSQ_BITS;
  localparam int ROOT_BITS   = OUTER_BITS + DIST_FRAC;
  localparam int REM_BITS    = ROOT_BITS + 2;
  localparam int NUM_BITS    = RAD_BITS + DIST_FRAC;
  localparam int BLEND_BITS  = HEIGHT_BITS + W_FRAC + 1;

  localparam logic [W_BITS-1:0]     W_ONE = W_BITS'(1) << W_FRAC;
  localparam logic [BLEND_BITS-1:0] ROUND = BLEND_BITS'(1) << (W_FRAC - 1);

  localparam int RESET_PAD     = 16;
  localparam int RESET_FALLOFF = 20;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_CENTER_X = CFG_INDEX_BITS'(0);
  localparam logic [CFG_INDEX_BITS-1:0] CFG_CENTER_Y = CFG_INDEX_BITS'(1);
  localparam logic [CFG_INDEX_BITS-1:0] CFG_TARGET   = CFG_INDEX_BITS'(2);
  localparam logic [CFG_INDEX_BITS-1:0] CFG_PAD      = CFG_INDEX_BITS'(3);
  localparam logic [CFG_INDEX_BITS-1:0] CFG_FALLOFF  = CFG_INDEX_BITS'(4);

  typedef enum logic [1:0] {
    REGION_KEEP = 2'd0,
    REGION_PAD  = 2'd1,
    REGION_RAMP = 2'd2
  } region_t;

  typedef struct packed {
    logic [COORD_BITS-1:0]  center_x;
    logic [COORD_BITS-1:0]  center_y;
    logic [HEIGHT_BITS-1:0] target_height;
    logic [RAD_BITS-1:0]    pad_radius;
    logic [RAD_BITS-1:0]    falloff_width;
    logic [RSQ_BITS-1:0]    r_sq;
    logic [OSQ_BITS-1:0]    outer_sq;
  } cfg_t;

  typedef struct packed {
    region_t                region;
    logic [HEIGHT_BITS-1:0] cur;
    logic [OSQ_BITS-1:0]    d2;
  } dist_t;

  typedef struct packed {
    region_t                region;
    logic [HEIGHT_BITS-1:0] cur;
    logic [ROOT_BITS-1:0]   dist_q8;
  } root_t;

  typedef struct packed {
    region_t                region;
    logic [HEIGHT_BITS-1:0] cur;
    logic [IDX_BITS-1:0]    idx;
  } idx_t;

  typedef struct packed {
    region_t                region;
    logic [HEIGHT_BITS-1:0] new_height;
  } result_t;

  typedef logic [W_BITS-1:0] curve_t [CURVE_ENTRIES];

  localparam logic [63:0] Q24_ONE = 64'd16777216;
  localparam logic [63:0] PI_Q24  = 64'd52707179;

  // shift-subtract quotient, elaboration only
  function automatic logic [63:0] div_u64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[63:0], n[i]};
      if (r >= {1'b0, d}) begin
        r = r - {1'b0, d};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // exp(x) in q.24 by truncated taylor series
  function automatic logic [63:0] exp_q24(input logic [63:0] x);
    logic [63:0] sum;
    logic [63:0] term;
    sum  = Q24_ONE;
    term = Q24_ONE;
    for (int k = 1; k < 48; k++) begin
      if (term != '0) begin
        term = div_u64((term * x) >> 24, 64'(k));
        sum  = sum + term;
      end
    end
    return sum;
  endfunction

  // tanh(x/2) in q.24
  function automatic logic [63:0] tanh_half_q24(input logic [63:0] x);
    logic [63:0] e;
    e = exp_q24(x);
    return div_u64((e - Q24_ONE) << 24, e + Q24_ONE);
  endfunction

  function automatic curve_t build_curve();
    curve_t      c;
    logic [63:0] t;
    logic [63:0] n;
    logic [63:0] twice;
    logic [63:0] m;
    logic [63:0] th;
    logic [63:0] num;
    t = tanh_half_q24(PI_Q24);
    n = 64'(CURVE_ENTRIES);
    for (int i = 0; i < CURVE_ENTRIES; i++) begin
      twice = 64'(2 * i);
      m     = (twice >= n) ? twice - n : n - twice;
      th    = tanh_half_q24(div_u64(PI_Q24 * m, n));
      if (th > t) begin
        th = t;
      end
      num  = (twice >= n) ? t + th : t - th;
      c[i] = W_BITS'(div_u64(num * 64'd4096 + t, 2 * t));
    end
    return c;
  endfunction

  localparam curve_t CURVE = build_curve();

endpackage
`default_nettype wire

### rtl/rfef_dist.sv
`timescale 1ns / 1ps
`default_nettype none
module rfef_dist (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              adv,
  input  rfef_pkg::cfg_t                    cfg,
  input  logic                              in_valid,
  input  logic [rfef_pkg::COORD_BITS-1:0]   cell_x,
  input  logic [rfef_pkg::COORD_BITS-1:0]   cell_y,
  input  logic [rfef_pkg::HEIGHT_BITS-1:0]  current_height,
  output logic                              out_valid,
  output rfef_pkg::dist_t                   out
);
  import rfef_pkg::*;

  logic [3:0]             valid;
  logic [COORD_BITS-1:0]  dx;
  logic [COORD_BITS-1:0]  dy;
  logic [COORD_BITS-1:0]  dx_next;
  logic [COORD_BITS-1:0]  dy_next;
  logic [HEIGHT_BITS-1:0] cur_a;
  logic [HEIGHT_BITS-1:0] cur_b;
  logic [HEIGHT_BITS-1:0] cur_c;
  logic [SQ_BITS-1:0]     sqx;
  logic [SQ_BITS-1:0]     sqy;
  logic [D2_BITS-1:0]     d2;
  region_t                cls;
  dist_t                  res;

  assign dx_next = (cell_x >= cfg.center_x) ? cell_x - cfg.center_x : cfg.center_x - cell_x;
  assign dy_next = (cell_y >= cfg.center_y) ? cell_y - cfg.center_y : cfg.center_y - cell_y;

  always_comb begin
    if (cfg.pad_radius == '0) begin
      cls = REGION_KEEP;
    end else if (d2 <= D2_BITS'(cfg.r_sq)) begin
      cls = REGION_PAD;
    end else if (d2 < D2_BITS'(cfg.outer_sq)) begin
      cls = REGION_RAMP;
    end else begin
      cls = REGION_KEEP;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (adv) begin
      valid <= {valid[2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dx    <= dx_next;
      dy    <= dy_next;
      cur_a <= current_height;
      sqx   <= dx * dx;
      sqy   <= dy * dy;
      cur_b <= cur_a;
      d2    <= D2_BITS'(sqx) + D2_BITS'(sqy);
      cur_c <= cur_b;
      // only ramp cells use d2 further, and those are below outer squared
      res   <= '{region: cls, cur: cur_c, d2: d2[OSQ_BITS-1:0]};
    end
  end

  assign out_valid = valid[3];
  assign out       = res;

endmodule
`default_nettype wire

### rtl/rfef_isqrt.sv
`timescale 1ns / 1ps
`default_nettype none
module rfef_isqrt (
  input  logic            clk,
  input  logic            rst,
  input  logic            adv,
  input  logic            in_valid,
  input  rfef_pkg::dist_t in,
  output logic            out_valid,
  output rfef_pkg::root_t out
);
  import rfef_pkg::*;

  localparam int RAD_W = 2 * ROOT_BITS;

  logic [ROOT_BITS-1:0] valid;
  logic [ROOT_BITS-1:0] root [ROOT_BITS];
  logic [REM_BITS-1:0]  rem  [ROOT_BITS];
  dist_t                item [ROOT_BITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (adv) begin
      valid <= {valid[ROOT_BITS-2:0], in_valid};
    end
  end

  // one root bit per stage, radicand is d2 in q.16
  genvar k;
  generate
    for (k = 0; k < ROOT_BITS; k++) begin : g_step
      dist_t                item_in;
      logic [ROOT_BITS-1:0] root_in;
      logic [REM_BITS-1:0]  rem_in;
      logic [REM_BITS-1:0]  rem_sh;
      logic [REM_BITS-1:0]  trial;
      logic [RAD_W-1:0]     rad;

      if (k == 0) begin : g_first
        assign item_in = in;
        assign root_in = '0;
        assign rem_in  = '0;
      end else begin : g_rest
        assign item_in = item[k-1];
        assign root_in = root[k-1];
        assign rem_in  = rem[k-1];
      end

      assign rad    = {item_in.d2, {(2 * DIST_FRAC){1'b0}}};
      assign rem_sh = {rem_in[REM_BITS-3:0], rad[RAD_W-1-2*k -: 2]};
      assign trial  = {root_in, 2'b01};

      always_ff @(posedge clk) begin
        if (adv) begin
          item[k] <= item_in;
          if (rem_sh >= trial) begin
            rem[k]  <= rem_sh - trial;
            root[k] <= {root_in[ROOT_BITS-2:0], 1'b1};
          end else begin
            rem[k]  <= rem_sh;
            root[k] <= {root_in[ROOT_BITS-2:0], 1'b0};
          end
        end
      end
    end
  endgenerate

  assign out_valid = valid[ROOT_BITS-1];
  assign out       = '{region:  item[ROOT_BITS-1].region,
                       cur:     item[ROOT_BITS-1].cur,
                       dist_q8: root[ROOT_BITS-1]};

endmodule
`default_nettype wire

### rtl/rfef_div.sv
`timescale 1ns / 1ps
`default_nettype none
module rfef_div (
  input  logic            clk,
  input  logic            rst,
  input  logic            adv,
  input  rfef_pkg::cfg_t  cfg,
  input  logic            in_valid,
  input  rfef_pkg::root_t in,
  output logic            out_valid,
  output rfef_pkg::idx_t  out
);
  import rfef_pkg::*;

  logic [IDX_BITS:0]    valid;
  idx_t                 prep;
  logic [NUM_BITS-1:0]  num;
  logic [NUM_BITS-1:0]  divisor;
  logic [ROOT_BITS-1:0] offset;
  logic [ROOT_BITS-1:0] diff;
  idx_t                 item [IDX_BITS];
  logic [NUM_BITS-1:0]  rem  [IDX_BITS];

  assign divisor = {cfg.falloff_width, {DIST_FRAC{1'b0}}};
  assign offset  = ROOT_BITS'({cfg.pad_radius, {DIST_FRAC{1'b0}}});
  // ramp cells have dist_q8 in [r*256, (r+f)*256)
  assign diff    = in.dist_q8 - offset;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (adv) begin
      valid <= {valid[IDX_BITS-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prep <= '{region: in.region, cur: in.cur, idx: '0};
      num  <= diff[NUM_BITS-1:0];
    end
  end

  // restoring division, one index bit per stage
  genvar j;
  generate
    for (j = 0; j < IDX_BITS; j++) begin : g_step
      idx_t                item_in;
      logic [NUM_BITS-1:0] rem_in;
      logic [NUM_BITS:0]   sh;

      if (j == 0) begin : g_first
        assign item_in = prep;
        assign rem_in  = num;
      end else begin : g_rest
        assign item_in = item[j-1];
        assign rem_in  = rem[j-1];
      end

      assign sh = {rem_in, 1'b0};

      always_ff @(posedge clk) begin
        if (adv) begin
          if (sh >= {1'b0, divisor}) begin
            rem[j]  <= NUM_BITS'(sh - {1'b0, divisor});
            item[j] <= '{region: item_in.region, cur: item_in.cur,
                         idx: {item_in.idx[IDX_BITS-2:0], 1'b1}};
          end else begin
            rem[j]  <= sh[NUM_BITS-1:0];
            item[j] <= '{region: item_in.region, cur: item_in.cur,
                         idx: {item_in.idx[IDX_BITS-2:0], 1'b0}};
          end
        end
      end
    end
  endgenerate

  assign out_valid = valid[IDX_BITS];
  assign out       = item[IDX_BITS-1];

endmodule
`default_nettype wire

### rtl/rfef_blend.sv
`timescale 1ns / 1ps
`default_nettype none
module rfef_blend (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  rfef_pkg::cfg_t    cfg,
  input  logic              in_valid,
  input  rfef_pkg::idx_t    in,
  output logic              out_valid,
  output rfef_pkg::result_t out
);
  import rfef_pkg::*;

  logic [2:0]             valid;
  logic [W_BITS-1:0]      w;
  region_t                region_l;
  region_t                region_m;
  logic [HEIGHT_BITS-1:0] cur_l;
  logic [HEIGHT_BITS-1:0] cur_m;
  logic [BLEND_BITS-1:0]  pa;
  logic [BLEND_BITS-1:0]  pb;
  logic [BLEND_BITS-1:0]  sum;
  logic [HEIGHT_BITS-1:0] blended;
  logic [HEIGHT_BITS-1:0] height_sel;
  result_t                res;

  assign sum     = pa + pb + ROUND;
  assign blended = sum[W_FRAC +: HEIGHT_BITS];

  always_comb begin
    case (region_m)
      REGION_PAD:  height_sel = cfg.target_height;
      REGION_RAMP: height_sel = blended;
      default:     height_sel = cur_m;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (adv) begin
      valid <= {valid[1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      w        <= CURVE[in.idx];
      region_l <= in.region;
      cur_l    <= in.cur;
      pa       <= cfg.target_height * (W_ONE - w);
      pb       <= cur_l * w;
      region_m <= region_l;
      cur_m    <= cur_l;
      res      <= '{region: region_m, new_height: height_sel};
    end
  end

  assign out_valid = valid[2];
  assign out       = res;

endmodule
`default_nettype wire

### rtl/radial_flatten_with_eased_falloff_core.sv
`timescale 1ns / 1ps
`default_nettype none
// channel  direction  handshake           payload
// cfg      in         cfg_we              cfg_index, cfg_data
// in       in         in_valid, in_stall  cell_x, cell_y, current_height
// out      out        out_valid, out_stall  new_height, region
//
// one item per cycle while in_stall is low; a result reaches out_valid by way of
// the 17-stage square-root pipe and the 9-stage divider for the curve index.
// rst is synchronous: it empties the pipe and loads the register defaults.
// a stalled result sits in the output register while one more item parks in a
// skid slot; in_stall rises only once that slot is full, and the pipe then holds.
module radial_flatten_with_eased_falloff_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [rfef_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [rfef_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [rfef_pkg::COORD_BITS-1:0]     cell_x,
  input  logic [rfef_pkg::COORD_BITS-1:0]     cell_y,
  input  logic [rfef_pkg::HEIGHT_BITS-1:0]    current_height,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [rfef_pkg::HEIGHT_BITS-1:0]    new_height,
  output logic [1:0]                          region
);
  import rfef_pkg::*;

  logic [COORD_BITS-1:0]  center_x;
  logic [COORD_BITS-1:0]  center_y;
  logic [HEIGHT_BITS-1:0] target_height;
  logic [RAD_BITS-1:0]    pad_radius;
  logic [RAD_BITS-1:0]    falloff_width;
  logic [RSQ_BITS-1:0]    r_sq;
  logic [OSQ_BITS-1:0]    outer_sq;
  logic [COORD_BITS-1:0]  center_x_next;
  logic [COORD_BITS-1:0]  center_y_next;
  logic [HEIGHT_BITS-1:0] target_height_next;
  logic [RAD_BITS-1:0]    pad_radius_next;
  logic [RAD_BITS-1:0]    falloff_width_next;
  logic [OUTER_BITS-1:0]  outer_next;
  cfg_t                   cfg;

  logic    adv;
  logic    skid_full;
  logic    out_take;
  logic    dist_valid;
  dist_t   dist_item;
  logic    root_valid;
  root_t   root_item;
  logic    idx_valid;
  idx_t    idx_item;
  logic    blend_valid;
  result_t blend_res;
  result_t out_res;
  result_t skid_res;

  always_comb begin
    center_x_next      = center_x;
    center_y_next      = center_y;
    target_height_next = target_height;
    pad_radius_next    = pad_radius;
    falloff_width_next = falloff_width;
    if (cfg_we) begin
      case (cfg_index)
        CFG_CENTER_X: center_x_next      = cfg_data[COORD_BITS-1:0];
        CFG_CENTER_Y: center_y_next      = cfg_data[COORD_BITS-1:0];
        CFG_TARGET:   target_height_next = cfg_data[HEIGHT_BITS-1:0];
        CFG_PAD:      pad_radius_next    = cfg_data[RAD_BITS-1:0];
        CFG_FALLOFF:  falloff_width_next = cfg_data[RAD_BITS-1:0];
        default:      ;
      endcase
    end
  end

  assign outer_next = {1'b0, pad_radius_next} + {1'b0, falloff_width_next};

  // squared radii follow the register writes in the same cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      center_x      <= '0;
      center_y      <= '0;
      target_height <= '0;
      pad_radius    <= RAD_BITS'(RESET_PAD);
      falloff_width <= RAD_BITS'(RESET_FALLOFF);
      r_sq          <= RSQ_BITS'(RESET_PAD * RESET_PAD);
      outer_sq      <= OSQ_BITS'((RESET_PAD + RESET_FALLOFF) * (RESET_PAD + RESET_FALLOFF));
    end else begin
      center_x      <= center_x_next;
      center_y      <= center_y_next;
      target_height <= target_height_next;
      pad_radius    <= pad_radius_next;
      falloff_width <= falloff_width_next;
      r_sq          <= pad_radius_next * pad_radius_next;
      outer_sq      <= outer_next * outer_next;
    end
  end

  assign cfg = '{center_x: center_x, center_y: center_y, target_height: target_height,
                 pad_radius: pad_radius, falloff_width: falloff_width,
                 r_sq: r_sq, outer_sq: outer_sq};

  assign adv      = !skid_full;
  assign in_stall = skid_full;
  assign out_take = out_valid && !out_stall;

  rfef_dist u_dist (
    .clk            (clk),
    .rst            (rst),
    .adv            (adv),
    .cfg            (cfg),
    .in_valid       (in_valid),
    .cell_x         (cell_x),
    .cell_y         (cell_y),
    .current_height (current_height),
    .out_valid      (dist_valid),
    .out            (dist_item)
  );

  rfef_isqrt u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (dist_valid),
    .in        (dist_item),
    .out_valid (root_valid),
    .out       (root_item)
  );

  rfef_div u_div (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .cfg       (cfg),
    .in_valid  (root_valid),
    .in        (root_item),
    .out_valid (idx_valid),
    .out       (idx_item)
  );

  rfef_blend u_blend (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .cfg       (cfg),
    .in_valid  (idx_valid),
    .in        (idx_item),
    .out_valid (blend_valid),
    .out       (blend_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_full <= 1'b0;
    end else if (skid_full) begin
      if (out_take) begin
        out_valid <= 1'b1;
        skid_full <= 1'b0;
      end
    end else if (!out_valid || out_take) begin
      out_valid <= blend_valid;
    end else if (blend_valid) begin
      skid_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_full) begin
      if (out_take) begin
        out_res <= skid_res;
      end
    end else if (!out_valid || out_take) begin
      out_res <= blend_res;
    end else if (blend_valid) begin
      skid_res <= blend_res;
    end
  end

  assign new_height = out_res.new_height;
  assign region     = out_res.region;

endmodule
`default_nettype wire

### rtl/rfef_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module rfef_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_valid,
  input logic                             in_stall,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic [rfef_pkg::HEIGHT_BITS-1:0] new_height,
  input logic [1:0]                       region
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(new_height) && $stable(region))
    else $error("stalled result changed");

  // the input side only backs up when a result is parked
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with empty output");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> $past(out_valid && out_stall))
    else $error("input stalled without a held result");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("reset left a result or a stall");

  a_stall_no_take: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid)
    else $error("stalled item withdrawn");

endmodule

bind radial_flatten_with_eased_falloff_core rfef_checker u_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .new_height (new_height),
  .region     (region)
);
`default_nettype wire

### verif/radial_flatten_with_eased_falloff_core_test.sv
`timescale 1ns / 1ps
module radial_flatten_with_eased_falloff_core_test;
  import rfef_pkg::*;

  typedef struct packed {
    logic [HEIGHT_BITS-1:0] height;
    region_t                zone;
  } height_zone_t;

  typedef struct packed {
    logic [COORD_BITS-1:0]  cen_x;
    logic [COORD_BITS-1:0]  cen_y;
    logic [HEIGHT_BITS-1:0] tgt;
    logic [RAD_BITS-1:0]    pad;
    logic [RAD_BITS-1:0]    fall;
    logic [COORD_BITS-1:0]  x;
    logic [COORD_BITS-1:0]  y;
    logic [HEIGHT_BITS-1:0] cur;
    bit                     typed;
    height_zone_t           want;
  } cell_row_t;

  localparam logic [63:0] ONE_Q24 = 64'd16777216;
  localparam logic [63:0] HALF_TURN_Q24 = 64'd52707179;
  localparam int RANDOM_SETUPS = 12;
  localparam int CELLS_PER_SETUP = 96;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;
  logic in_valid;
  logic in_stall;
  logic [COORD_BITS-1:0] cell_x;
  logic [COORD_BITS-1:0] cell_y;
  logic [HEIGHT_BITS-1:0] current_height;
  logic out_valid;
  logic out_stall;
  logic [HEIGHT_BITS-1:0] new_height;
  logic [1:0] region;

  // register copies seen by the flatten predictor
  logic [COORD_BITS-1:0] set_cx;
  logic [COORD_BITS-1:0] set_cy;
  logic [HEIGHT_BITS-1:0] set_tgt;
  logic [RAD_BITS-1:0] set_pad;
  logic [RAD_BITS-1:0] set_fall;

  logic [W_BITS-1:0] ease_curve [CURVE_ENTRIES];
  height_zone_t queued_heights [$];
  int height_errors = 0;
  bit calm = 1'b0;

  cell_row_t directed_rows [25] = '{
    // reset setup: centre at origin, target 0, pad 16, ramp 20
    '{0, 0, 0, 16, 20, 0, 0, 200, 1, '{0, REGION_PAD}},
    '{0, 0, 0, 16, 20, 16, 0, 77, 1, '{0, REGION_PAD}},
    '{0, 0, 0, 16, 20, 0, 16, 255, 1, '{0, REGION_PAD}},
    // just past the pad edge the curve weight is zero
    '{0, 0, 0, 16, 20, 16, 1, 99, 1, '{0, REGION_RAMP}},
    '{0, 0, 0, 16, 20, 17, 0, 77, 0, '{0, REGION_KEEP}},
    '{0, 0, 0, 16, 20, 25, 20, 180, 0, '{0, REGION_KEEP}},
    '{0, 0, 0, 16, 20, 35, 0, 255, 0, '{0, REGION_KEEP}},
    '{0, 0, 0, 16, 20, 36, 0, 50, 1, '{50, REGION_KEEP}},
    '{0, 0, 0, 16, 20, 1023, 1023, 255, 1, '{255, REGION_KEEP}},
    // centre at the far corner, no wrap of the distance
    '{1023, 1023, 255, 16, 20, 1023, 1023, 0, 1, '{255, REGION_PAD}},
    '{1023, 1023, 255, 16, 20, 0, 0, 0, 1, '{0, REGION_KEEP}},
    '{1023, 1023, 255, 16, 20, 1003, 1023, 0, 0, '{0, REGION_KEEP}},
    '{1023, 1023, 255, 16, 20, 1023, 990, 128, 0, '{0, REGION_KEEP}},
    // widest pad and ramp
    '{512, 512, 128, 255, 255, 767, 512, 3, 1, '{128, REGION_PAD}},
    '{512, 512, 128, 255, 255, 812, 512, 7, 0, '{0, REGION_KEEP}},
    '{512, 512, 128, 255, 255, 1021, 512, 200, 0, '{0, REGION_KEEP}},
    '{512, 512, 128, 255, 255, 0, 0, 9, 1, '{9, REGION_KEEP}},
    '{512, 512, 128, 255, 255, 1023, 1023, 255, 1, '{255, REGION_KEEP}},
    // radius zero leaves everything alone
    '{300, 700, 40, 0, 255, 300, 700, 33, 1, '{33, REGION_KEEP}},
    '{300, 700, 40, 0, 255, 305, 700, 0, 1, '{0, REGION_KEEP}},
    // no ramp ring
    '{300, 700, 40, 10, 0, 310, 700, 91, 1, '{40, REGION_PAD}},
    '{300, 700, 40, 10, 0, 311, 700, 91, 1, '{91, REGION_KEEP}},
    // smallest pad and ring
    '{5, 1000, 200, 1, 1, 6, 1000, 0, 1, '{200, REGION_PAD}},
    '{5, 1000, 200, 1, 1, 6, 1001, 0, 0, '{0, REGION_KEEP}},
    '{5, 1000, 200, 1, 1, 7, 1000, 0, 1, '{0, REGION_KEEP}}
  };

  radial_flatten_with_eased_falloff_core uut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .cell_x(cell_x),
    .cell_y(cell_y),
    .current_height(current_height),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .new_height(new_height),
    .region(region)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [63:0] exp_fix(input logic [63:0] x);
    logic [63:0] acc;
    logic [63:0] term;
    acc = ONE_Q24;
    term = ONE_Q24;
    for (int k = 1; k < 48 && term != 0; k++) begin
      term = ((term * x) >> 24) / 64'(k);
      acc = acc + term;
    end
    return acc;
  endfunction

  function automatic logic [63:0] tanh_half_fix(input logic [63:0] x);
    logic [63:0] e;
    e = exp_fix(x);
    return ((e - ONE_Q24) << 24) / (e + ONE_Q24);
  endfunction

  // s-curve weights, 0 at the pad edge rising toward 4096 at the outer edge
  function automatic void fill_ease_table();
    logic [63:0] top;
    logic [63:0] twice;
    logic [63:0] m;
    logic [63:0] th;
    logic [63:0] num;
    top = tanh_half_fix(HALF_TURN_Q24);
    for (int i = 0; i < CURVE_ENTRIES; i++) begin
      twice = 64'(2 * i);
      m = (twice >= CURVE_ENTRIES) ? twice - CURVE_ENTRIES : CURVE_ENTRIES - twice;
      th = tanh_half_fix((HALF_TURN_Q24 * m) / CURVE_ENTRIES);
      if (th > top) th = top;
      num = (twice >= CURVE_ENTRIES) ? top + th : top - th;
      ease_curve[i] = W_BITS'((num * 4096 + top) / (2 * top));
    end
  endfunction

  function automatic logic [63:0] root_floor(input logic [63:0] v);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] b;
    rem = v;
    res = 0;
    b = 64'd1 << 62;
    while (b > rem) b = b >> 2;
    while (b != 0) begin
      if (rem >= res + b) begin
        rem = rem - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic height_zone_t flatten_cell(input logic [COORD_BITS-1:0] x,
                                                input logic [COORD_BITS-1:0] y,
                                                input logic [HEIGHT_BITS-1:0] c);
    height_zone_t res;
    logic [63:0] dx;
    logic [63:0] dy;
    logic [63:0] d2;
    logic [63:0] r;
    logic [63:0] f;
    logic [63:0] outer;
    logic [63:0] dist_q8;
    logic [63:0] lin;
    logic [63:0] idx;
    logic [63:0] w;
    dx = (x >= set_cx) ? 64'(x - set_cx) : 64'(set_cx - x);
    dy = (y >= set_cy) ? 64'(y - set_cy) : 64'(set_cy - y);
    d2 = dx * dx + dy * dy;
    r = 64'(set_pad);
    f = 64'(set_fall);
    outer = r + f;
    res.height = c;
    res.zone = REGION_KEEP;
    if (r != 0) begin
      if (d2 <= r * r) begin
        res.height = set_tgt;
        res.zone = REGION_PAD;
      end else if (f != 0 && d2 < outer * outer) begin
        dist_q8 = root_floor(d2 << 16);
        lin = ((dist_q8 - (r << 8)) << 12) / (f << 8);
        if (lin > 4095) lin = 4095;
        idx = (lin * CURVE_ENTRIES) >> 12;
        if (idx >= CURVE_ENTRIES) idx = CURVE_ENTRIES - 1;
        w = 64'(ease_curve[idx]);
        if (w > 4096) w = 4096;
        res.height = HEIGHT_BITS'((64'(set_tgt) * (4096 - w) + 64'(c) * w + 2048) >> 12);
        res.zone = REGION_RAMP;
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    if (height_errors < 40) $display("mismatch at %0t ns: %s", $time, what);
    height_errors++;
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    case (idx)
      CFG_CENTER_X: set_cx = data[COORD_BITS-1:0];
      CFG_CENTER_Y: set_cy = data[COORD_BITS-1:0];
      CFG_TARGET: set_tgt = data[HEIGHT_BITS-1:0];
      CFG_PAD: set_pad = data[RAD_BITS-1:0];
      CFG_FALLOFF: set_fall = data[RAD_BITS-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic load_setup(input logic [COORD_BITS-1:0] cx, input logic [COORD_BITS-1:0] cy,
                            input logic [HEIGHT_BITS-1:0] tgt, input logic [RAD_BITS-1:0] pad,
                            input logic [RAD_BITS-1:0] fall);
    logic [CFG_DATA_BITS-1:0] junk;
    junk = CFG_DATA_BITS'($urandom);
    write_reg(CFG_CENTER_X, CFG_DATA_BITS'(cx));
    write_reg(CFG_CENTER_Y, CFG_DATA_BITS'(cy));
    // upper data bits above the narrow registers must be dropped
    write_reg(CFG_TARGET, {junk[CFG_DATA_BITS-1:HEIGHT_BITS], tgt});
    write_reg(CFG_PAD, {junk[CFG_DATA_BITS-1:RAD_BITS], pad});
    write_reg(CFG_FALLOFF, {junk[CFG_DATA_BITS-1:RAD_BITS], fall});
  endtask

  task automatic write_unused_reg();
    write_reg(CFG_INDEX_BITS'($urandom_range(CFG_FALLOFF + 1, (1 << CFG_INDEX_BITS) - 1)),
              CFG_DATA_BITS'($urandom));
  endtask

  // called at a falling edge; returns at the falling edge after the item is taken
  task automatic send_cell(input logic [COORD_BITS-1:0] x, input logic [COORD_BITS-1:0] y,
                           input logic [HEIGHT_BITS-1:0] c, input bit typed,
                           input height_zone_t given);
    height_zone_t want;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_valid = 1'b1;
    cell_x = x;
    cell_y = y;
    current_height = c;
    want = typed ? given : flatten_cell(x, y, c);
    do @(posedge clk); while (in_stall);
    queued_heights = {queued_heights, want};
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid = 1'b0;
    while (queued_heights.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  always @(posedge clk) begin : watch_results
    height_zone_t want;
    if (!rst && out_valid && !out_stall) begin
      if (queued_heights.size() == 0) begin
        report_mismatch($sformatf("unexpected item height %0d region %0d", new_height, region));
      end else begin
        want = queued_heights.pop_front();
        if (new_height !== want.height)
          report_mismatch($sformatf("height %0d, predicted %0d", new_height, want.height));
        if (region !== want.zone)
          report_mismatch($sformatf("region %0d, predicted %0d", region, want.zone));
      end
    end
  end

  initial begin : stall_bursts
    out_stall = 1'b0;
    forever begin
      repeat (($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 8)) @(negedge clk);
      if (!calm && $urandom_range(0, 2) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 6)) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  initial begin : main_flow
    cell_row_t row;
    logic [RAD_BITS-1:0] pad;
    logic [RAD_BITS-1:0] fall;
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    int span;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    cell_x = '0;
    cell_y = '0;
    current_height = '0;
    set_cx = '0;
    set_cy = '0;
    set_tgt = '0;
    set_pad = RAD_BITS'(RESET_PAD);
    set_fall = RAD_BITS'(RESET_FALLOFF);
    fill_ease_table();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // a write to a missing register must leave the reset setup intact
    write_unused_reg();
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.cen_x != set_cx || row.cen_y != set_cy || row.tgt != set_tgt ||
          row.pad != set_pad || row.fall != set_fall) begin
        settle();
        load_setup(row.cen_x, row.cen_y, row.tgt, row.pad, row.fall);
      end
      send_cell(row.x, row.y, row.cur, row.typed, row.want);
    end

    for (int s = 0; s < RANDOM_SETUPS; s++) begin
      settle();
      case (s)
        0: begin pad = 8'd255; fall = 8'd255; end
        1: begin pad = 8'd0; fall = RAD_BITS'($urandom); end
        2: begin pad = RAD_BITS'($urandom_range(1, 60)); fall = 8'd0; end
        3: begin pad = 8'd1; fall = 8'd1; end
        4: begin pad = RAD_BITS'($urandom_range(1, 8)); fall = 8'd255; end
        default: begin
          pad = RAD_BITS'(($urandom_range(0, 3) == 0) ? $urandom_range(1, 255)
                                                       : $urandom_range(1, 40));
          fall = RAD_BITS'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                        : $urandom_range(1, 40));
        end
      endcase
      load_setup(COORD_BITS'($urandom), COORD_BITS'($urandom), HEIGHT_BITS'($urandom), pad,
                 fall);
      if ($urandom_range(0, 1) == 0) write_unused_reg();
      calm = (s == RANDOM_SETUPS - 1);
      span = int'(set_pad) + int'(set_fall) + 3;
      for (int n = 0; n < CELLS_PER_SETUP; n++) begin
        // mostly cells around the disc so the pad and ramp get real traffic
        if ($urandom_range(0, 4) != 0) begin
          x = COORD_BITS'(int'(set_cx) + int'($urandom_range(0, 2 * span)) - span);
          y = COORD_BITS'(int'(set_cy) + int'($urandom_range(0, 2 * span)) - span);
        end else begin
          x = COORD_BITS'($urandom);
          y = COORD_BITS'($urandom);
        end
        send_cell(x, y, HEIGHT_BITS'($urandom), 1'b0, '0);
      end
    end

    in_valid = 1'b0;
    while (queued_heights.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (height_errors == 0) begin
      $display("radial_flatten_with_eased_falloff_core_test OK");
    end else begin
      $display("radial_flatten_with_eased_falloff_core_test NOT OK");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("radial_flatten_with_eased_falloff_core_test NOT OK");
    $finish;
  end

endmodule

### radial_flatten_with_eased_falloff_core.f
rtl/rfef_pkg.sv
rtl/rfef_dist.sv
rtl/rfef_isqrt.sv
rtl/rfef_div.sv
rtl/rfef_blend.sv
rtl/radial_flatten_with_eased_falloff_core.sv
rtl/rfef_checker.sv
verif/radial_flatten_with_eased_falloff_core_test.sv
